[rtl/sact_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_pkg
// shared types, constants and codes for the cache tag and policy block
// ----------------------------------------------------------------------------
package sact_pkg;

    localparam int MAX_SETS_DEF = 256;
    localparam int MAX_WAYS_DEF = 8;
    localparam int MEM_COST     = 100;

    typedef enum logic [2:0]
    {
        CFG_SET_BITS  = 3'd0,
        CFG_OFF_BITS  = 3'd1,
        CFG_WAYS      = 3'd2,
        CFG_WALLOC    = 3'd3,
        CFG_WTHRU     = 3'd4,
        CFG_FIFO      = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_CLEAR,
        ST_LOOK,
        ST_OUT
    } sact_state_t;

    typedef struct packed
    {
        logic        op;
        logic [31:0] address;
    } req_t;

    typedef struct packed
    {
        logic        hit;
        logic        dirty_evicted;
        logic [17:0] cycles_added;
    } rsp_t;

    typedef struct packed
    {
        logic clr_start;
        logic clr_step;
        logic capture;
        logic read;
        logic update;
    } sact_cmd_t;

    typedef struct packed
    {
        logic clr_done;
    } sact_sts_t;

endpackage

[rtl/sact_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_ctrl
// access sequencer: clearing pass, lookup, update and result hand-off
// ----------------------------------------------------------------------------
module sact_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output sact_pkg::sact_cmd_t cmd,
    input  sact_pkg::sact_sts_t sts
);
    import sact_pkg::*;

    sact_state_t state_reg;
    sact_state_t state_next;
    logic        clr_begun_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_begun_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_begun_reg <= 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_start = !clr_begun_reg;
                cmd.clr_step  = clr_begun_reg;
                if (clr_begun_reg && sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.read    = 1'b1;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.update = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        cmd.read    = 1'b1;
                        state_next  = ST_LOOK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/sact_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_dp
// tag store, way compare, victim choice, stamps and cost computation
// ----------------------------------------------------------------------------
module sact_dp
#(
    parameter int MAX_SETS = sact_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS = sact_pkg::MAX_WAYS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [3:0]          cfg_data,
    input  sact_pkg::req_t      in_word,
    output sact_pkg::rsp_t      out_word,
    input  sact_pkg::sact_cmd_t cmd,
    output sact_pkg::sact_sts_t sts
);
    import sact_pkg::*;

    localparam int SB = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int LIM_RAW = $clog2(MAX_SETS + 1) - 1;
    localparam int LIM = (LIM_RAW > 12) ? 12 : LIM_RAW;
    localparam int WB = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CB = $clog2(MAX_WAYS + 1);

    typedef struct packed
    {
        logic        valid;
        logic        dirty;
        logic [31:0] tag;
        logic [31:0] use_st;
        logic [31:0] fill_st;
    } line_t;

    logic [3:0] sbits_reg, obits_reg, ways_reg;
    logic       walloc_reg, wthru_reg, fifo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbits_reg  <= 4'd0;
            obits_reg  <= 4'd4;
            ways_reg   <= 4'd1;
            walloc_reg <= 1'b1;
            wthru_reg  <= 1'b0;
            fifo_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SET_BITS: sbits_reg  <= cfg_data;
                CFG_OFF_BITS: obits_reg  <= cfg_data;
                CFG_WAYS:     ways_reg   <= cfg_data;
                CFG_WALLOC:   walloc_reg <= cfg_data[0];
                CFG_WTHRU:    wthru_reg  <= cfg_data[0];
                CFG_FIFO:     fifo_reg   <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // effective geometry
    logic [3:0]  ob, sb;
    logic [CB-1:0] nways;
    always_comb
    begin
        ob = obits_reg;
        if (ob < 4'd2)
        begin
            ob = 4'd2;
        end
        if (ob > 4'd12)
        begin
            ob = 4'd12;
        end
        sb = sbits_reg;
        if (32'(sb) > 32'(LIM))
        begin
            sb = 4'(LIM);
        end
        if (ways_reg == 4'd0)
        begin
            nways = CB'(1);
        end
        else if (32'(ways_reg) > 32'(MAX_WAYS))
        begin
            nways = CB'(MAX_WAYS);
        end
        else
        begin
            nways = CB'(ways_reg);
        end
    end

    // captured access
    logic          op_reg;
    logic [SB-1:0] set_reg;
    logic [31:0]   tag_reg;
    logic [17:0]   fcost_reg;
    logic [31:0]   stamp_reg;
    logic [SB-1:0] clr_reg;
    rsp_t          rsp_reg;

    logic [31:0] sh_set, tag_c;
    logic [4:0]  osum;
    assign sh_set = in_word.address >> ob;
    assign osum   = 5'(ob) + 5'(sb);
    assign tag_c  = (osum > 5'd31) ? 32'd0 : (in_word.address >> osum);

    line_t mem [MAX_WAYS][MAX_SETS];
    line_t rd_reg [MAX_WAYS];

    logic [MAX_WAYS-1:0] wr_en;
    line_t               wr_line;
    logic [SB-1:0]       wr_addr;

    // lookup and victim choice
    logic          hit_c, do_fill, dev_c;
    logic [WB-1:0] hway, vway;
    logic          inv_found;
    logic [31:0]   a, b;
    logic [17:0]   cyc_c;
    line_t         vline;

    genvar g;
    generate
        for (g = 0; g < MAX_WAYS; g++)
        begin : g_way
            always_ff @(posedge clk)
            begin
                if (wr_en[g])
                begin
                    mem[g][wr_addr] <= wr_line;
                end
                if (cmd.read)
                begin
                    rd_reg[g] <= mem[g][SB'(sh_set & ((32'd1 << sb) - 32'd1))];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_word.op;
            set_reg   <= SB'(sh_set & ((32'd1 << sb) - 32'd1));
            tag_reg   <= tag_c;
            fcost_reg <= 18'(MEM_COST) << (ob - 4'd2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg <= 32'd0;
            clr_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_start)
            begin
                clr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + SB'(1);
            end
            if (cmd.update && do_fill)
            begin
                stamp_reg <= stamp_reg + 32'd1;
            end
        end
    end

    assign sts.clr_done = (32'(clr_reg) == MAX_SETS - 1);

    always_comb
    begin
        hit_c     = 1'b0;
        hway      = '0;
        vway      = '0;
        inv_found = 1'b0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (CB'(w) < nways && rd_reg[w].valid && rd_reg[w].tag == tag_reg)
            begin
                hit_c = 1'b1;
                hway  = WB'(w);
            end
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            a = fifo_reg ? rd_reg[w].fill_st : rd_reg[w].use_st;
            b = fifo_reg ? rd_reg[vway].fill_st : rd_reg[vway].use_st;
            if (CB'(w) < nways && !inv_found)
            begin
                if (!rd_reg[w].valid)
                begin
                    vway      = WB'(w);
                    inv_found = 1'b1;
                end
                else if (w != 0 && a < b)
                begin
                    vway = WB'(w);
                end
            end
        end
        vline   = rd_reg[vway];
        do_fill = hit_c || !op_reg || walloc_reg;
        dev_c   = 1'b0;
        cyc_c   = 18'd0;
        wr_en   = '0;
        wr_addr = set_reg;
        wr_line = rd_reg[hway];
        if (hit_c)
        begin
            cyc_c          = 18'd1;
            wr_line.use_st = stamp_reg + 32'd1;
            if (op_reg)
            begin
                if (wthru_reg)
                begin
                    cyc_c = 18'd1 + 18'(MEM_COST);
                end
                else
                begin
                    wr_line.dirty = 1'b1;
                end
            end
            wr_en[hway] = cmd.update;
        end
        else if (do_fill)
        begin
            dev_c = vline.valid && vline.dirty;
            cyc_c = dev_c ? (fcost_reg << 1) : fcost_reg;
            if (op_reg && wthru_reg)
            begin
                cyc_c = cyc_c + 18'(MEM_COST);
            end
            wr_line.valid   = 1'b1;
            wr_line.dirty   = op_reg && !wthru_reg;
            wr_line.tag     = tag_reg;
            wr_line.use_st  = stamp_reg + 32'd1;
            wr_line.fill_st = stamp_reg + 32'd1;
            wr_en[vway]     = cmd.update;
        end
        else
        begin
            cyc_c = 18'(MEM_COST);
        end
        if (cmd.clr_step || cmd.clr_start)
        begin
            wr_en         = '1;
            wr_addr       = cmd.clr_start ? '0 : clr_reg;
            wr_line       = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            rsp_reg <= '{hit: hit_c, dirty_evicted: dev_c, cycles_added: cyc_c};
        end
    end

    assign out_word = rsp_reg;

endmodule

[rtl/set_assoc_cache_tag_policy.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_policy
// set-associative cache tag store with lru or fifo replacement
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready/in_word) carries one access word: op and
//   byte address. out channel (out_valid/out_ready/out_word) returns hit,
//   dirty eviction flag and cycle cost for that access.
//   config port (cfg_we/cfg_index/cfg_data) writes geometry and policy
//   registers at once; write only while the block is idle.
//   access: the accept edge reads all ways of the set into registers; in
//   ST_LOOK the block compares, chooses the victim, writes back and
//   registers the result, which ST_OUT then shows until it is taken. a
//   new word can be accepted only once the previous result is taken.
//   a new word is accepted in the same cycle the previous result is taken.
//   reset: a clearing pass zeroes every set of the tag store in all ways,
//   during which in_ready stays low.
//   a stalled receiver holds the result and blocks new words.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_policy
#(
    parameter int MAX_SETS = sact_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS = sact_pkg::MAX_WAYS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [3:0]     cfg_data,
    input  logic           in_valid,
    output logic           in_ready,
    input  sact_pkg::req_t in_word,
    output logic           out_valid,
    input  logic           out_ready,
    output sact_pkg::rsp_t out_word
);
    import sact_pkg::*;

    sact_cmd_t cmd;
    sact_sts_t sts;

    sact_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    sact_dp #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .out_word  (out_word),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[rtl/sact_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_checker
// port-level checks for the cache tag and policy block
// ----------------------------------------------------------------------------
module sact_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input sact_pkg::rsp_t out_word
);
    import sact_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result dropped or changed under stall");

    a_no_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("word accepted while result stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid ##1 out_valid)
        else $error("result not shown two cycles after accept");

    a_hit_cost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.hit |-> !out_word.dirty_evicted &&
        (out_word.cycles_added == 18'd1 || out_word.cycles_added == 18'(MEM_COST + 1)))
        else $error("bad hit result");

endmodule

bind set_assoc_cache_tag_policy sact_checker u_sact_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);
